>>> hw/rtl/palette_blend_nearest_color_top_defines.svh
// ----------------------------------------------------------------------------
// palette blend nearest color - assertion macros
// shared check shorthands for the checker bound to the top level
// ----------------------------------------------------------------------------
`ifndef PALETTE_BLEND_NEAREST_COLOR_TOP_DEFINES_SVH
`define PALETTE_BLEND_NEAREST_COLOR_TOP_DEFINES_SVH

// consequent holds in the same cycle as the antecedent
`define PBNC_ASSERT_SAME(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("pbnc check failed");

// consequent holds in the cycle after the antecedent
`define PBNC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("pbnc check failed");

`endif

>>> hw/rtl/pbnc_pkg.sv
// ----------------------------------------------------------------------------
// pbnc_pkg
// shared types and constants of the palette blend nearest color block
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package pbnc_pkg;

  // one palette color, red in the top byte
  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } rgb_t;

  // percent register
  localparam int unsigned PctW     = 7;
  localparam logic [6:0]  PctFull  = 7'd100;
  localparam logic [6:0]  PctReset = 7'd20;

  // blend arithmetic: mix <= 255 * 100, divide by 100 via reciprocal
  localparam int unsigned MixW        = 15;
  localparam int unsigned RecipW      = 13;
  localparam logic [12:0] Div100Mul   = 13'd5243;
  localparam int unsigned Div100Shift = 19;
  localparam int unsigned ProdW       = MixW + RecipW;

  // distance arithmetic
  localparam int unsigned SqW   = 16;
  localparam int unsigned DistW = 18;

  // commands
  localparam logic CmdWrite = 1'b0;
  localparam logic CmdQuery = 1'b1;

  // control from the sequencer to the search unit
  typedef struct packed {
    logic clr;
    logic vld;
    logic last;
  } search_ctl_t;

  typedef enum logic [6:0] {
    ST_IDLE   = 7'b0000001,
    ST_WRITE  = 7'b0000010,
    ST_FETCH  = 7'b0000100,
    ST_MIX    = 7'b0001000,
    ST_BLEND  = 7'b0010000,
    ST_SEARCH = 7'b0100000,
    ST_DRAIN  = 7'b1000000
  } state_e;

endpackage

`default_nettype wire

>>> hw/rtl/pbnc_cell.sv
// ----------------------------------------------------------------------------
// pbnc_cell
// one palette cell of the rotating ring
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module pbnc_cell (
  input  logic          clk_i,
  input  pbnc_pkg::rgb_t nb_i,
  input  logic          ld_i,
  input  pbnc_pkg::rgb_t ld_data_i,
  output pbnc_pkg::rgb_t ent_o
);
  import pbnc_pkg::*;

  rgb_t ent_q, ent_d;

  always_comb begin
    ent_d = ld_i ? ld_data_i : nb_i;
  end

  always_ff @(posedge clk_i) begin
    ent_q <= ent_d;
  end

  assign ent_o = ent_q;

endmodule

`default_nettype wire

>>> hw/rtl/pbnc_ring.sv
// ----------------------------------------------------------------------------
// pbnc_ring
// palette ring: a chain of cells shifting toward the head every cycle
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module pbnc_ring #(
  parameter int unsigned Entries = 256,
  parameter int unsigned IdxW    = 8
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            wr_i,
  input  pbnc_pkg::rgb_t  wr_data_i,
  output pbnc_pkg::rgb_t  head_o,
  output logic [IdxW-1:0] head_idx_o
);
  import pbnc_pkg::*;

  rgb_t ent [Entries];

  logic [IdxW-1:0] head_idx_q, head_idx_d;

  // cell k takes from cell k+1, the tail takes the head back or a new entry
  for (genvar k = 0; k < Entries; k++) begin : g_cell
    localparam int unsigned Nb     = (k + 1) % Entries;
    localparam bit          IsTail = (k == Entries - 1);

    pbnc_cell u_cell (
      .clk_i     (clk_i),
      .nb_i      (ent[Nb]),
      .ld_i      (wr_i & IsTail),
      .ld_data_i (wr_data_i),
      .ent_o     (ent[k])
    );
  end

  always_comb begin
    if (head_idx_q == IdxW'(Entries - 1)) begin
      head_idx_d = '0;
    end else begin
      head_idx_d = head_idx_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_idx_q <= '0;
    end else begin
      head_idx_q <= head_idx_d;
    end
  end

  assign head_o     = ent[0];
  assign head_idx_o = head_idx_q;

endmodule

`default_nettype wire

>>> hw/rtl/pbnc_blend.sv
// ----------------------------------------------------------------------------
// pbnc_blend
// two-stage per-channel blend of two colors by a percent weight
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module pbnc_blend (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           start_i,
  input  pbnc_pkg::rgb_t c1_i,
  input  pbnc_pkg::rgb_t c2_i,
  input  logic [6:0]     pct_i,
  output logic           vld_o,
  output pbnc_pkg::rgb_t mix_o
);
  import pbnc_pkg::*;

  logic [2:0][7:0]      a, b;
  logic [PctW-1:0]      p, q;
  logic [2:0][MixW-1:0] mix_q, mix_d;
  logic [2:0][7:0]      res_q, res_d;
  logic [2:0][ProdW-1:0] prod;
  logic                 v1_q, v2_q;

  assign a = c1_i;
  assign b = c2_i;

  // percent above full saturates
  always_comb begin
    p = (pct_i > PctFull) ? PctFull : pct_i;
    q = PctFull - p;
  end

  // stage 1: weighted sum
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      mix_d[k] = MixW'(a[k]) * MixW'(p) + MixW'(b[k]) * MixW'(q);
    end
  end

  // stage 2: divide by 100 through the reciprocal, exact below 25600
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      prod[k]  = ProdW'(mix_q[k]) * ProdW'(Div100Mul);
      res_d[k] = 8'(prod[k] >> Div100Shift);
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      mix_q <= mix_d;
    end
    if (v1_q) begin
      res_q <= res_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
    end else begin
      v1_q <= start_i;
      v2_q <= v1_q;
    end
  end

  assign vld_o = v2_q;
  assign mix_o = res_q;

endmodule

`default_nettype wire

>>> hw/rtl/pbnc_search.sv
// ----------------------------------------------------------------------------
// pbnc_search
// pipelined squared distance and running minimum over streamed entries
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module pbnc_search #(
  parameter int unsigned IdxW = 8
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  pbnc_pkg::search_ctl_t ctl_i,
  input  pbnc_pkg::rgb_t        mix_i,
  input  pbnc_pkg::rgb_t        ent_i,
  input  logic [IdxW-1:0]       idx_i,
  output logic                  done_o,
  output logic [IdxW-1:0]       best_idx_o
);
  import pbnc_pkg::*;

  logic [2:0][7:0]     m, e, dif;
  logic [2:0][SqW-1:0] sq_q, sq_d;
  logic [IdxW-1:0]     idx1_q;
  logic                v1_q, last1_q, done_q;
  logic [DistW-1:0]    sum;
  logic                better;
  logic [DistW-1:0]    best_d_q, best_d_d;
  logic [IdxW-1:0]     best_idx_q, best_idx_d;

  assign m = mix_i;
  assign e = ent_i;

  // stage 1: per-channel squared difference
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      dif[k]  = (m[k] >= e[k]) ? (m[k] - e[k]) : (e[k] - m[k]);
      sq_d[k] = SqW'(dif[k]) * SqW'(dif[k]);
    end
  end

  // stage 2: total distance, lower index wins a tie
  always_comb begin
    sum    = DistW'(sq_q[0]) + DistW'(sq_q[1]) + DistW'(sq_q[2]);
    better = (sum < best_d_q) || ((sum == best_d_q) && (idx1_q < best_idx_q));
    best_d_d   = best_d_q;
    best_idx_d = best_idx_q;
    if (ctl_i.clr) begin
      best_d_d = '1;
    end else if (v1_q && better) begin
      best_d_d   = sum;
      best_idx_d = idx1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    sq_q       <= sq_d;
    idx1_q     <= idx_i;
    best_d_q   <= best_d_d;
    best_idx_q <= best_idx_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q    <= 1'b0;
      last1_q <= 1'b0;
      done_q  <= 1'b0;
    end else begin
      v1_q    <= ctl_i.vld;
      last1_q <= ctl_i.vld & ctl_i.last;
      done_q  <= v1_q & last1_q;
    end
  end

  assign done_o     = done_q;
  assign best_idx_o = best_idx_q;

endmodule

`default_nettype wire

>>> hw/rtl/palette_blend_nearest_color_top.sv
// ----------------------------------------------------------------------------
// palette_blend_nearest_color_top
// palette store with blended-color nearest entry search
// ----------------------------------------------------------------------------
// The palette lives in a ring of PALETTE_ENTRIES cells that rotates by one
// entry every cycle, so each entry passes the head once per revolution. A
// word is taken when start is high and busy is low. A write word waits at
// most one revolution for its slot to reach the head; a write to an index
// beyond the palette is dropped at once. A query word first waits for both
// named entries to pass the head, blends them, then streams one full
// revolution through the distance unit and drains the search pipeline. The
// result is shown on nearest_index_o for exactly one cycle with done_o high,
// in the same cycle busy falls; the receiver cannot stall, so capture it
// then. Entries must be written before a query reads them. The user must
// write blend_percent on the cfg port only while busy is low; the block
// itself does not enforce it.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module palette_blend_nearest_color_top #(
  parameter int unsigned PALETTE_ENTRIES = 256
) (
  input  logic       clk_i,
  input  logic       rst_ni,

  // command channel
  input  logic       start,
  output logic       busy,
  input  logic       command_i,
  input  logic [7:0] entry_index_i,
  input  logic [7:0] red_in_i,
  input  logic [7:0] green_in_i,
  input  logic [7:0] blue_in_i,
  input  logic [7:0] first_color_i,
  input  logic [7:0] second_color_i,

  // result strobe
  output logic       done_o,
  output logic [7:0] nearest_index_o,

  // blend_percent write channel
  input  logic       cfg_valid_i,
  output logic       cfg_ready_o,
  input  logic [6:0] cfg_data_i
);
  import pbnc_pkg::*;

  localparam int unsigned IDX_W = $clog2(PALETTE_ENTRIES);

  // sequencer state
  state_e state_q, state_d;

  // pending write
  logic [IDX_W-1:0] w_idx_q, w_idx_d;
  rgb_t             w_rgb_q, w_rgb_d;

  // query operands, got flags mark entries already captured
  logic [IDX_W-1:0] f1_q, f1_d, f2_q, f2_d;
  logic             g1_q, g1_d, g2_q, g2_d;
  rgb_t             c1_q, c1_d, c2_q, c2_d;

  // search sweep counter
  logic [IDX_W-1:0] cnt_q, cnt_d;

  // config and result
  logic [PctW-1:0]  pct_q;
  logic             done_q, done_d;
  logic [7:0]       nearest_q, nearest_d;

  // ring, blend and search hookup
  rgb_t             head;
  logic [IDX_W-1:0] head_idx;
  logic             wr_hit;
  logic             blend_vld;
  rgb_t             mix;
  search_ctl_t      sctl;
  logic             srch_done;
  logic [IDX_W-1:0] best_idx;

  logic accept, entry_ok, first_ok, second_ok, hit1, hit2;

  assign accept    = start && !busy;
  assign entry_ok  = 32'(entry_index_i) < PALETTE_ENTRIES;
  assign first_ok  = 32'(first_color_i) < PALETTE_ENTRIES;
  assign second_ok = 32'(second_color_i) < PALETTE_ENTRIES;

  // the pending write lands as its slot leaves the head for the tail
  assign wr_hit = (state_q == ST_WRITE) && (head_idx == w_idx_q);

  // operand capture while the ring goes round
  assign hit1 = !g1_q && (head_idx == f1_q);
  assign hit2 = !g2_q && (head_idx == f2_q);

  always_comb begin
    state_d   = state_q;
    w_idx_d   = w_idx_q;
    w_rgb_d   = w_rgb_q;
    f1_d      = f1_q;
    f2_d      = f2_q;
    g1_d      = g1_q;
    g2_d      = g2_q;
    c1_d      = c1_q;
    c2_d      = c2_q;
    cnt_d     = cnt_q;
    done_d    = 1'b0;
    nearest_d = nearest_q;

    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          if (command_i == CmdQuery) begin
            // an index beyond the palette reads as black
            f1_d    = IDX_W'(first_color_i);
            f2_d    = IDX_W'(second_color_i);
            g1_d    = !first_ok;
            g2_d    = !second_ok;
            c1_d    = '0;
            c2_d    = '0;
            state_d = ST_FETCH;
          end else if (entry_ok) begin
            w_idx_d = IDX_W'(entry_index_i);
            w_rgb_d = '{red: red_in_i, green: green_in_i, blue: blue_in_i};
            state_d = ST_WRITE;
          end
        end
      end
      ST_WRITE: begin
        if (wr_hit) begin
          state_d = ST_IDLE;
        end
      end
      ST_FETCH: begin
        if (hit1) begin
          c1_d = head;
          g1_d = 1'b1;
        end
        if (hit2) begin
          c2_d = head;
          g2_d = 1'b1;
        end
        if ((g1_q || hit1) && (g2_q || hit2)) begin
          state_d = ST_MIX;
        end
      end
      ST_MIX: begin
        state_d = ST_BLEND;
      end
      ST_BLEND: begin
        if (blend_vld) begin
          cnt_d   = '0;
          state_d = ST_SEARCH;
        end
      end
      ST_SEARCH: begin
        // one revolution from any head position covers every entry once
        cnt_d = cnt_q + 1'b1;
        if (sctl.last) begin
          state_d = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (srch_done) begin
          nearest_d = 8'(best_idx);
          done_d    = 1'b1;
          state_d   = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    sctl.clr  = (state_q == ST_BLEND) && blend_vld;
    sctl.vld  = (state_q == ST_SEARCH);
    sctl.last = (cnt_q == IDX_W'(PALETTE_ENTRIES - 1));
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    w_idx_q   <= w_idx_d;
    w_rgb_q   <= w_rgb_d;
    f1_q      <= f1_d;
    f2_q      <= f2_d;
    c1_q      <= c1_d;
    c2_q      <= c2_d;
    cnt_q     <= cnt_d;
    nearest_q <= nearest_d;
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      g1_q    <= 1'b0;
      g2_q    <= 1'b0;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      g1_q    <= g1_d;
      g2_q    <= g2_d;
      done_q  <= done_d;
    end
  end

  // blend_percent register, always ready
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pct_q <= PctReset;
    end else if (cfg_valid_i && cfg_ready_o) begin
      pct_q <= cfg_data_i;
    end
  end

  pbnc_ring #(
    .Entries (PALETTE_ENTRIES),
    .IdxW    (IDX_W)
  ) u_ring (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .wr_i       (wr_hit),
    .wr_data_i  (w_rgb_q),
    .head_o     (head),
    .head_idx_o (head_idx)
  );

  pbnc_blend u_blend (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (state_q == ST_MIX),
    .c1_i    (c1_q),
    .c2_i    (c2_q),
    .pct_i   (pct_q),
    .vld_o   (blend_vld),
    .mix_o   (mix)
  );

  pbnc_search #(
    .IdxW (IDX_W)
  ) u_search (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .ctl_i      (sctl),
    .mix_i      (mix),
    .ent_i      (head),
    .idx_i      (head_idx),
    .done_o     (srch_done),
    .best_idx_o (best_idx)
  );

  assign busy            = (state_q != ST_IDLE);
  assign done_o          = done_q;
  assign nearest_index_o = nearest_q;
  assign cfg_ready_o     = 1'b1;

endmodule

`default_nettype wire

>>> hw/rtl/pbnc_checker.sv
// ----------------------------------------------------------------------------
// pbnc_checker
// port-level checks bound to the top level
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "palette_blend_nearest_color_top_defines.svh"

module pbnc_checker (
  input logic clk_i,
  input logic rst_ni,
  input logic start,
  input logic busy,
  input logic command_i,
  input logic done_o
);

  // a result comes only at the end of work
  `PBNC_ASSERT_SAME(a_done_after_busy, clk_i, rst_ni, done_o, $past(busy))

  // the block is free again when it shows a result
  `PBNC_ASSERT_SAME(a_done_when_idle, clk_i, rst_ni, done_o, !busy)

  // one strobe per query
  `PBNC_ASSERT_NEXT(a_done_single, clk_i, rst_ni, done_o, !done_o)

  // a query word always keeps the block busy afterwards
  `PBNC_ASSERT_NEXT(a_query_busy, clk_i, rst_ni, start && !busy && command_i, busy)

endmodule

bind palette_blend_nearest_color_top pbnc_checker u_pbnc_checker (.*);

`default_nettype wire

>>> sim/palette_blend_nearest_color_top_tb.sv
// ----------------------------------------------------------------------------
// palette_blend_nearest_color_top_tb
// self-checking bench for the palette blend nearest color block
// ----------------------------------------------------------------------------
// Loads the whole palette first, then sends a few hand-picked words and
// random write/query mixes under a series of blend_percent settings. Each
// accepted word runs through a local model of the palette and blend search.
// The resulting nearest index is queued and checked against done_o results
// in arrival order. The sender idles at random, except for one phase that
// runs back to back.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module palette_blend_nearest_color_top_tb;

  import pbnc_pkg::*;

  localparam int unsigned Entries = 256;
  // one query: both operands pass the head, blend, a full sweep and drain
  localparam int unsigned Settle  = 2 * Entries + 16;
  localparam int unsigned IdlePct = 11;

  // one command word as the sender presents it
  typedef struct {
    logic       cmd;
    logic [7:0] entry;
    rgb_t       color;
    logic [7:0] first;
    logic [7:0] second;
  } palette_cmd_t;

  logic       clk_i          = 1'b0;
  logic       rst_ni         = 1'b0;
  logic       start          = 1'b0;
  logic       busy;
  logic       command_i      = CmdWrite;
  logic [7:0] entry_index_i  = 8'd0;
  logic [7:0] red_in_i       = 8'd0;
  logic [7:0] green_in_i     = 8'd0;
  logic [7:0] blue_in_i      = 8'd0;
  logic [7:0] first_color_i  = 8'd0;
  logic [7:0] second_color_i = 8'd0;
  logic       done_o;
  logic [7:0] nearest_index_o;
  logic       cfg_valid_i    = 1'b0;
  logic       cfg_ready_o;
  logic [6:0] cfg_data_i     = 7'd0;

  palette_blend_nearest_color_top #(
    .PALETTE_ENTRIES(Entries)
  ) u_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start          (start),
    .busy           (busy),
    .command_i      (command_i),
    .entry_index_i  (entry_index_i),
    .red_in_i       (red_in_i),
    .green_in_i     (green_in_i),
    .blue_in_i      (blue_in_i),
    .first_color_i  (first_color_i),
    .second_color_i (second_color_i),
    .done_o         (done_o),
    .nearest_index_o(nearest_index_o),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_ready_o    (cfg_ready_o),
    .cfg_data_i     (cfg_data_i)
  );

  // 10 ns clock
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // shadow state and prediction
  // ---------------------------------------------------------------------------
  rgb_t         palette_copy [Entries];
  logic [6:0]   percent_copy = PctReset;
  logic [7:0]   nearest_q [$];   // expected nearest indices, oldest first
  palette_cmd_t pending_q [$];   // words not yet offered to the block
  palette_cmd_t cur_word;        // word currently on the command ports
  bit           steady = 1'b0;   // no sender gaps while set
  int           errors   = 0;
  int           n_writes = 0;
  int           n_queries = 0;
  int           n_checked = 0;
  int           n_settings = 0;

  // blend two palette entries and sweep the palette for the closest color
  function automatic logic [7:0] nearest_entry(input logic [7:0] a_idx,
                                               input logic [7:0] b_idx);
    int unsigned pct, mr, mg, mb, dr, dg, db, sq_dist, best_dist;
    logic [7:0]  best;
    rgb_t        ca, cb;
    pct = (percent_copy > PctFull) ? PctFull : percent_copy;  // saturate
    ca  = palette_copy[a_idx];
    cb  = palette_copy[b_idx];
    mr  = (ca.red   * pct + cb.red   * (100 - pct)) / 100;
    mg  = (ca.green * pct + cb.green * (100 - pct)) / 100;
    mb  = (ca.blue  * pct + cb.blue  * (100 - pct)) / 100;
    best      = 8'd0;
    best_dist = 32'hFFFF_FFFF;
    for (int i = 0; i < Entries; i++) begin
      dr   = (mr > palette_copy[i].red)   ? mr - palette_copy[i].red
                                          : palette_copy[i].red - mr;
      dg   = (mg > palette_copy[i].green) ? mg - palette_copy[i].green
                                          : palette_copy[i].green - mg;
      db   = (mb > palette_copy[i].blue)  ? mb - palette_copy[i].blue
                                          : palette_copy[i].blue - mb;
      sq_dist = dr * dr + dg * dg + db * db;
      // strict compare keeps the lowest index on ties and on exact matches
      if (sq_dist < best_dist) begin
        best      = 8'(i);
        best_dist = sq_dist;
      end
    end
    return best;
  endfunction

  // apply one accepted word to the shadow palette or queue its answer
  task automatic take_word(input palette_cmd_t w);
    if (w.cmd == CmdWrite) begin
      palette_copy[w.entry] = w.color;
      n_writes++;
    end else begin
      nearest_q.push_back(nearest_entry(w.first, w.second));
      n_queries++;
    end
  endtask

  // ---------------------------------------------------------------------------
  // driver: offers queued words, holds each until start && !busy
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin
    bit offer;
    offer = start;
    if (!rst_ni) begin
      offer = 1'b0;
    end else begin
      if (start && !busy) begin
        take_word(cur_word);
        offer = 1'b0;
      end
      if (!offer) begin
        if (pending_q.size() != 0 && (steady || $urandom_range(99) >= IdlePct)) begin
          cur_word       = pending_q.pop_front();
          offer          = 1'b1;
          command_i      <= cur_word.cmd;
          entry_index_i  <= cur_word.entry;
          red_in_i       <= cur_word.color.red;
          green_in_i     <= cur_word.color.green;
          blue_in_i      <= cur_word.color.blue;
          first_color_i  <= cur_word.first;
          second_color_i <= cur_word.second;
        end else begin
          // idle cycle: junk on the fields, start stays low
          command_i      <= 1'($urandom);
          entry_index_i  <= 8'($urandom);
          red_in_i       <= 8'($urandom);
          green_in_i     <= 8'($urandom);
          blue_in_i      <= 8'($urandom);
          first_color_i  <= 8'($urandom);
          second_color_i <= 8'($urandom);
        end
      end
    end
    start <= offer;
  end

  // blend_percent shadow follows the config handshake
  always @(posedge clk_i) begin
    if (rst_ni && cfg_valid_i && cfg_ready_o) begin
      percent_copy <= cfg_data_i;
    end
  end

  // ---------------------------------------------------------------------------
  // monitor: every done_o pulse must match the oldest expected index
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin
    logic [7:0] want;
    if (rst_ni && done_o) begin
      if (nearest_q.size() == 0) begin
        $display("%0t unexpected result: expected none, actual %0d",
                 $time, nearest_index_o);
        errors++;
      end else begin
        want = nearest_q.pop_front();
        n_checked++;
        if (nearest_index_o !== want) begin
          $display("%0t nearest_index mismatch: expected %0d, actual %0d",
                   $time, want, nearest_index_o);
          errors++;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // word builders
  // ---------------------------------------------------------------------------
  // coarse colors land on a five-level grid so duplicates and ties show up
  function automatic rgb_t pick_color(input bit coarse);
    rgb_t c;
    if (coarse) begin
      c.red   = 8'(($urandom_range(4) * 255) / 4);
      c.green = 8'(($urandom_range(4) * 255) / 4);
      c.blue  = 8'(($urandom_range(4) * 255) / 4);
    end else begin
      c = rgb_t'(24'($urandom));
    end
    return c;
  endfunction

  // writes carry junk in the query operands, queries junk in the write fields
  task automatic push_write(input logic [7:0] idx, input rgb_t c);
    palette_cmd_t w;
    w.cmd    = CmdWrite;
    w.entry  = idx;
    w.color  = c;
    w.first  = 8'($urandom);
    w.second = 8'($urandom);
    pending_q.push_back(w);
  endtask

  task automatic push_query(input logic [7:0] a, input logic [7:0] b);
    palette_cmd_t w;
    w.cmd    = CmdQuery;
    w.entry  = 8'($urandom);
    w.color  = rgb_t'(24'($urandom));
    w.first  = a;
    w.second = b;
    pending_q.push_back(w);
  endtask

  // random mix: some palette rewrites, mostly queries, some self-blends
  task automatic push_mix(input int count, input bit coarse);
    logic [7:0] a;
    for (int k = 0; k < count; k++) begin
      if ($urandom_range(99) < 35) begin
        push_write(8'($urandom), pick_color(coarse || $urandom_range(3) == 0));
      end else begin
        a = 8'($urandom);
        push_query(a, ($urandom_range(4) == 0) ? a : 8'($urandom));
      end
    end
  endtask

  // hold the sender until every word is taken and every answer has come
  task automatic drain;
    int waited;
    waited = 0;
    while (pending_q.size() != 0 || start) @(posedge clk_i);
    while ((nearest_q.size() != 0 || busy) && waited < 4 * Settle) begin
      @(posedge clk_i);
      waited++;
    end
    if (nearest_q.size() != 0) begin
      $display("%0t %0d queries never answered, expected index %0d first",
               $time, nearest_q.size(), nearest_q[0]);
      errors++;
      nearest_q.delete();
    end
    // writes give no result, so let a possible late one finish
    repeat (Settle) @(posedge clk_i);
  endtask

  task automatic write_percent(input logic [6:0] pct);
    @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= pct;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    cfg_data_i  <= 7'($urandom);
    n_settings++;
  endtask

  // ---------------------------------------------------------------------------
  // sequence
  // ---------------------------------------------------------------------------
  initial begin
    logic [6:0] pct_plan [11];
    pct_plan = '{7'd0, 7'd100, 7'd127, 7'd101, 7'd50, 7'd1, 7'd99, 7'd33,
                 7'd20, 7'd0, 7'd0};
    pct_plan[9]  = 7'($urandom_range(127));
    pct_plan[10] = 7'($urandom_range(100));

    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;

    // every entry must hold a color before the first sweep reads it
    for (int i = 0; i < Entries; i++) begin
      push_write(8'(i), pick_color(i % 3 == 0));
    end

    // hand-picked words at the reset percent of 20
    push_write(8'd0,   '{8'h00, 8'h00, 8'h00});   // black at the bottom
    push_write(8'd255, '{8'hFF, 8'hFF, 8'hFF});   // white at the top
    push_write(8'd1,   '{8'hFF, 8'hFF, 8'hFF});   // duplicate white, lower index
    push_write(8'd128, '{8'hFF, 8'h00, 8'h80});
    push_write(8'd200, '{8'h00, 8'hFF, 8'h7F});
    push_query(8'd0,   8'd0);                     // exact match on entry 0
    push_query(8'd255, 8'd255);                   // duplicate: entry 1 wins
    push_query(8'd0,   8'd255);
    push_query(8'd255, 8'd0);
    push_query(8'd128, 8'd200);
    push_query(8'd200, 8'd128);
    push_write(8'd2,   '{8'h33, 8'h33, 8'h33});   // 20% of white exactly
    push_query(8'd1,   8'd0);
    push_query(8'd0,   8'd1);
    push_mix(70, 1'b0);
    drain();

    // one setting per phase, extremes and saturation among them
    foreach (pct_plan[ph]) begin
      write_percent(pct_plan[ph]);
      steady = (ph == 3);
      if (ph == 1 || ph == 2 || ph == 3) begin
        // at full weight a blend gives the first entry's own color
        push_query(8'd255, 8'd0);
        push_query(8'd0,   8'd255);
      end
      push_mix(50, ph % 2 == 1);
      drain();
    end
    steady = 1'b0;

    $display("covered %0d palette writes and %0d blend queries, %0d results checked",
             n_writes, n_queries, n_checked);
    $display("blend percent: reset value plus %0d writes incl. 0, 100 and 101..127",
             n_settings);
    if (errors == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  // hang guard, several times the slowest legal run
  initial begin
    #40_000_000;
    $display("timeout at %0t with %0d results outstanding", $time, nearest_q.size());
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule

>>> filelist.f
+incdir+hw/rtl
hw/rtl/pbnc_pkg.sv
hw/rtl/pbnc_cell.sv
hw/rtl/pbnc_ring.sv
hw/rtl/pbnc_blend.sv
hw/rtl/pbnc_search.sv
hw/rtl/palette_blend_nearest_color_top.sv
hw/rtl/pbnc_checker.sv
sim/palette_blend_nearest_color_top_tb.sv
